### hdl/rlfr_pkg.sv
// Shared types and constants for the radio link frame receiver.
// Used by rlfr_parse and radio_link_frame_receiver_top; no dependencies.
package rlfr_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_IGNORED  = 3'd0,
    ST_OPENED   = 3'd1,
    ST_INSIDE   = 3'd2,
    ST_COMPLETE = 3'd3,
    ST_ERROR    = 3'd4
  } status_t;

  // Frame kinds
  typedef enum logic {
    KIND_REPLY = 1'b0,
    KIND_DATA  = 1'b1
  } kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_REPLY_HEADER     = 2'd0,
    REG_REPLY_MAX_PARAMS = 2'd1,
    REG_DATA_MAX_LENGTH  = 2'd2,
    REG_UNUSED           = 2'd3
  } reg_index_t;

  localparam logic [7:0] DATA_OPEN_BYTE = 8'h24;  // '$'
  localparam logic [7:0] REPLY_OVERHEAD = 8'd3;   // header, address, length

  // Configuration register values
  typedef struct packed {
    logic [7:0] reply_header;
    logic [7:0] reply_max_params;
    logic [7:0] data_max_length;
  } cfg_t;

  // Frame tracking state
  typedef struct packed {
    logic       in_frame;
    kind_t      kind;
    logic [7:0] kept_count;
    logic [7:0] declared_length;
  } frame_state_t;

  // One result beat
  typedef struct packed {
    status_t    status;
    logic       kept;
    logic [7:0] kept_index;
    logic [7:0] kept_byte;
    kind_t      frame_kind;
    logic [7:0] frame_length;
  } result_t;

endpackage

### hdl/radio_link_frame_receiver_top.sv
// Radio link frame receiver: input register, frame recognition, result register.
// Depends on rlfr_pkg and rlfr_parse.
//
// Usage:
//   Input channel (in_valid, in_stall, rx_byte) takes one received serial byte
//   per beat. Output channel (out_valid, out_stall, status, kept, kept_index,
//   kept_byte, frame_kind, frame_length) returns exactly one result beat per
//   input byte, in order. Configuration writes (cfg_valid, cfg_ready,
//   cfg_index, cfg_data) set reply_header (0), reply_max_params (1) and
//   data_max_length (2); cfg_ready is always high. Write only while idle.
//   Each accepted byte passes through the input register, then the result
//   register. Throughput: one byte per cycle while out_stall is not held.
//   Reset (rst, synchronous) empties both registers, returns the frame
//   tracker to idle and loads the register defaults 193, 32, 32.
//   When the receiver holds out_stall, the result holds; one more byte can
//   sit in the input register, after which in_stall rises until the result
//   is taken.
module radio_link_frame_receiver_top #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic       kept,
  output logic [7:0] kept_index,
  output logic [7:0] kept_byte,
  output logic       frame_kind,
  output logic [7:0] frame_length,
  // configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  rlfr_pkg::cfg_t         cfg;
  rlfr_pkg::frame_state_t frame_state;
  rlfr_pkg::frame_state_t frame_state_next;
  rlfr_pkg::result_t      step_result;
  rlfr_pkg::result_t      out_result;

  logic       in_byte_valid;
  logic [7:0] in_byte;
  logic       out_free;
  logic       advance;
  logic       in_accept;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reply_header     <= 8'd193;
      cfg.reply_max_params <= 8'd32;
      cfg.data_max_length  <= 8'd32;
    end else if (cfg_valid && cfg_ready) begin
      case (rlfr_pkg::reg_index_t'(cfg_index))
        rlfr_pkg::REG_REPLY_HEADER:     cfg.reply_header     <= cfg_data;
        rlfr_pkg::REG_REPLY_MAX_PARAMS: cfg.reply_max_params <= cfg_data;
        rlfr_pkg::REG_DATA_MAX_LENGTH:  cfg.data_max_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the byte moves on when the result register is free
  assign out_free  = !out_valid || !out_stall;
  assign advance   = in_byte_valid && out_free;
  assign in_stall  = in_byte_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_byte_valid <= 1'b0;
    end else if (in_accept) begin
      in_byte_valid <= 1'b1;
    end else if (advance) begin
      in_byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte <= rx_byte;
    end
  end

  rlfr_parse #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parse (
    .cfg       (cfg),
    .state     (frame_state),
    .rx_byte   (in_byte),
    .state_next(frame_state_next),
    .result    (step_result)
  );

  // Frame state advances with each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_state <= '0;
    end else if (advance) begin
      frame_state <= frame_state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign status       = out_result.status;
  assign kept         = out_result.kept;
  assign kept_index   = out_result.kept_index;
  assign kept_byte    = out_result.kept_byte;
  assign frame_kind   = out_result.frame_kind;
  assign frame_length = out_result.frame_length;

endmodule

### hdl/rlfr_parse.sv
// Frame recognition step: next frame state and result for one received byte.
// Depends on rlfr_pkg.
module rlfr_parse #(
  parameter int BUFFER_BYTES = 64
) (
  input  rlfr_pkg::cfg_t         cfg,
  input  rlfr_pkg::frame_state_t state,
  input  logic [7:0]             rx_byte,
  output rlfr_pkg::frame_state_t state_next,
  output rlfr_pkg::result_t      result
);

  localparam logic [7:0] BUF_LIMIT = 8'(BUFFER_BYTES);

  logic [7:0] count_inc;
  logic [8:0] reply_total;
  logic       done;
  logic       err;
  rlfr_pkg::frame_state_t work;

  assign count_inc   = state.kept_count + 8'd1;
  assign reply_total = {1'b0, state.declared_length} + {1'b0, rlfr_pkg::REPLY_OVERHEAD};

  always_comb begin
    work   = state;
    done   = 1'b0;
    err    = 1'b0;
    result = '0;
    result.status     = rlfr_pkg::ST_IGNORED;
    result.frame_kind = rlfr_pkg::KIND_REPLY;

    if (!state.in_frame) begin
      // Idle: look for an opening byte, reply header first
      if (rx_byte == cfg.reply_header) begin
        work.in_frame      = 1'b1;
        work.kind          = rlfr_pkg::KIND_REPLY;
        work.kept_count    = 8'd1;
        result.status      = rlfr_pkg::ST_OPENED;
        result.kept        = 1'b1;
        result.kept_index  = 8'd0;
        result.kept_byte   = rx_byte;
      end else if (rx_byte == rlfr_pkg::DATA_OPEN_BYTE) begin
        work.in_frame      = 1'b1;
        work.kind          = rlfr_pkg::KIND_DATA;
        work.kept_count    = 8'd0;
        result.status      = rlfr_pkg::ST_OPENED;
        result.frame_kind  = rlfr_pkg::KIND_DATA;
      end
    end else begin
      result.frame_kind = state.kind;
      if (state.kind == rlfr_pkg::KIND_REPLY) begin
        // Reply: keep every byte, the third one carries the length
        result.kept       = 1'b1;
        result.kept_index = state.kept_count;
        result.kept_byte  = rx_byte;
        work.kept_count   = count_inc;
        if (count_inc == rlfr_pkg::REPLY_OVERHEAD) begin
          work.declared_length = rx_byte;
          err = (rx_byte > cfg.reply_max_params);
        end else if (reply_total == {1'b0, count_inc}) begin
          done = 1'b1;
        end
      end else begin
        // Data: length byte, payload, then an unchecked trailer
        if (state.declared_length == 8'd0) begin
          work.declared_length = rx_byte;
          err = (rx_byte > cfg.data_max_length);
        end else if (state.declared_length == state.kept_count) begin
          done = 1'b1;
        end else begin
          result.kept       = 1'b1;
          result.kept_index = state.kept_count;
          result.kept_byte  = rx_byte;
          work.kept_count   = count_inc;
        end
      end

      // Buffer full wins over completion
      if (work.kept_count >= BUF_LIMIT) begin
        err = 1'b1;
      end

      if (err) begin
        result.status = rlfr_pkg::ST_ERROR;
        work          = '0;
      end else if (done) begin
        result.status       = rlfr_pkg::ST_COMPLETE;
        result.frame_length = work.kept_count;
        work                = '0;
      end else begin
        result.status = rlfr_pkg::ST_INSIDE;
      end
    end
  end

  assign state_next = work;

endmodule

### sim/rlfr_result_checker.sv
// Result checker for radio_link_frame_receiver_top: tracks frames byte by byte,
// queues the expected result for each accepted input beat and compares output beats.
// Depends on rlfr_pkg.
module rlfr_result_checker #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [2:0] status,
  input  logic       kept,
  input  logic [7:0] kept_index,
  input  logic [7:0] kept_byte,
  input  logic       frame_kind,
  input  logic [7:0] frame_length,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         mismatches,
  output int         results_due
);

  rlfr_pkg::cfg_t         link_cfg;
  rlfr_pkg::frame_state_t tracker;
  rlfr_pkg::result_t      frame_results_due[$];
  int                     beats_seen;

  // Advance the frame tracker by one received byte and return what the block should report
  function automatic rlfr_pkg::result_t track_frame_byte(input logic [7:0] b);
    rlfr_pkg::result_t r;
    logic    done;
    logic    err;
    r = '0;
    r.status = rlfr_pkg::ST_IGNORED;
    r.frame_kind = rlfr_pkg::KIND_REPLY;
    done = 1'b0;
    err = 1'b0;
    if (!tracker.in_frame) begin
      // Reply header wins over the data opener when both match
      if (b == link_cfg.reply_header) begin
        tracker.in_frame = 1'b1;
        tracker.kind = rlfr_pkg::KIND_REPLY;
        tracker.kept_count = 8'd1;
        r.status = rlfr_pkg::ST_OPENED;
        r.kept = 1'b1;
        r.kept_index = 8'd0;
        r.kept_byte = b;
      end else if (b == rlfr_pkg::DATA_OPEN_BYTE) begin
        tracker.in_frame = 1'b1;
        tracker.kind = rlfr_pkg::KIND_DATA;
        tracker.kept_count = 8'd0;
        r.status = rlfr_pkg::ST_OPENED;
        r.frame_kind = rlfr_pkg::KIND_DATA;
      end
    end else begin
      r.frame_kind = tracker.kind;
      if (tracker.kind == rlfr_pkg::KIND_REPLY) begin
        // Keep every reply byte; the third one is the parameter count
        r.kept = 1'b1;
        r.kept_index = tracker.kept_count;
        r.kept_byte = b;
        tracker.kept_count = tracker.kept_count + 8'd1;
        if (tracker.kept_count == rlfr_pkg::REPLY_OVERHEAD) begin
          tracker.declared_length = b;
          err = (b > link_cfg.reply_max_params);
        end else if (int'(tracker.declared_length) + int'(rlfr_pkg::REPLY_OVERHEAD)
                     == int'(tracker.kept_count)) begin
          done = 1'b1;
        end
      end else begin
        // Data frame: length byte (again while zero), payload, then trailer
        if (tracker.declared_length == 8'd0) begin
          tracker.declared_length = b;
          err = (b > link_cfg.data_max_length);
        end else if (tracker.declared_length == tracker.kept_count) begin
          done = 1'b1;
        end else begin
          r.kept = 1'b1;
          r.kept_index = tracker.kept_count;
          r.kept_byte = b;
          tracker.kept_count = tracker.kept_count + 8'd1;
        end
      end
      // A full buffer beats completion on the same byte
      if (int'(tracker.kept_count) >= BUFFER_BYTES) err = 1'b1;
      if (err) begin
        r.status = rlfr_pkg::ST_ERROR;
        tracker = '0;
      end else if (done) begin
        r.status = rlfr_pkg::ST_COMPLETE;
        r.frame_length = tracker.kept_count;
        tracker = '0;
      end else begin
        r.status = rlfr_pkg::ST_INSIDE;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatches < 40)
      $display("t=%0t result beat %0d: %s got %0h expected %0h",
               $time, beats_seen, what, got, want);
    mismatches++;
  endtask

  // Watch all three channels; queue on input beats, compare on output beats
  always @(posedge clk) begin
    rlfr_pkg::result_t want;
    if (rst) begin
      link_cfg.reply_header = 8'd193;
      link_cfg.reply_max_params = 8'd32;
      link_cfg.data_max_length = 8'd32;
      tracker = '0;
      frame_results_due.delete();
      mismatches = 0;
      beats_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (rlfr_pkg::reg_index_t'(cfg_index))
          rlfr_pkg::REG_REPLY_HEADER:     link_cfg.reply_header = cfg_data;
          rlfr_pkg::REG_REPLY_MAX_PARAMS: link_cfg.reply_max_params = cfg_data;
          rlfr_pkg::REG_DATA_MAX_LENGTH:  link_cfg.data_max_length = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) frame_results_due.push_back(track_frame_byte(rx_byte));
      if (out_valid && !out_stall) begin
        if (frame_results_due.size() == 0) begin
          report_mismatch("beat with nothing due, status", 8'(status),
                          8'(rlfr_pkg::ST_IGNORED));
        end else begin
          want = frame_results_due.pop_front();
          if (status !== want.status)
            report_mismatch("status", 8'(status), 8'(want.status));
          if (kept !== want.kept)
            report_mismatch("kept", 8'(kept), 8'(want.kept));
          if (kept_index !== want.kept_index)
            report_mismatch("kept_index", kept_index, want.kept_index);
          if (kept_byte !== want.kept_byte)
            report_mismatch("kept_byte", kept_byte, want.kept_byte);
          if (frame_kind !== want.frame_kind)
            report_mismatch("frame_kind", 8'(frame_kind), 8'(want.frame_kind));
          if (frame_length !== want.frame_length)
            report_mismatch("frame_length", frame_length, want.frame_length);
        end
        beats_seen++;
      end
    end
    results_due <= frame_results_due.size();
  end

endmodule

### sim/testbench.sv
// Top of the radio_link_frame_receiver_top regression: clock, reset, byte stimulus,
// register settings and the verdict. Depends on rlfr_pkg, the block and rlfr_result_checker.
module testbench;

  localparam int BUFFER_BYTES = 64;

  // Directed opening: ignored extremes, zero then real data length, short reply,
  // and both kinds of over-limit length
  localparam logic [7:0] OPENING_BYTES [17] = '{
    8'h00, 8'hFF,
    rlfr_pkg::DATA_OPEN_BYTE, 8'h00, 8'h02, 8'hFF, 8'h00, 8'hA5,
    8'hC1, 8'h00, 8'h01, 8'h7E,
    rlfr_pkg::DATA_OPEN_BYTE, 8'h21,
    8'hC1, 8'h11, 8'h21
  };

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] status;
  logic       kept;
  logic [7:0] kept_index;
  logic [7:0] kept_byte;
  logic       frame_kind;
  logic [7:0] frame_length;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  int         mismatch_count;
  int         results_due;
  int         bytes_sent = 0;
  bit         no_gaps = 1'b0;
  logic       hold_go;
  logic       sink_hold;
  logic [7:0] cur_hdr = 8'd193;
  logic [7:0] cur_rmax = 8'd32;
  logic [7:0] cur_dmax = 8'd32;

  always #10 clk = ~clk;

  radio_link_frame_receiver_top #(.BUFFER_BYTES(BUFFER_BYTES)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .kept(kept),
    .kept_index(kept_index), .kept_byte(kept_byte), .frame_kind(frame_kind),
    .frame_length(frame_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rlfr_result_checker #(.BUFFER_BYTES(BUFFER_BYTES)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .kept(kept),
    .kept_index(kept_index), .kept_byte(kept_byte), .frame_kind(frame_kind),
    .frame_length(frame_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatch_count), .results_due(results_due)
  );

  // Offer one byte after a random gap and hold it until the block takes the beat
  task automatic send_rx_byte(input logic [7:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Drop valid and wait until every expected result beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all registers back to back; optionally poke the unused index too
  task automatic apply_settings(input logic [7:0] hdr, input logic [7:0] rmax,
                                input logic [7:0] dmax, input bit touch_unused);
    rlfr_pkg::reg_index_t idx [4];
    logic [7:0] val [4];
    int         count;
    idx = '{rlfr_pkg::REG_REPLY_HEADER, rlfr_pkg::REG_REPLY_MAX_PARAMS,
            rlfr_pkg::REG_DATA_MAX_LENGTH, rlfr_pkg::REG_UNUSED};
    val = '{hdr, rmax, dmax, 8'($urandom)};
    count = touch_unused ? 4 : 3;
    for (int i = 0; i < count; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cur_hdr = hdr;
    cur_rmax = rmax;
    cur_dmax = dmax;
  endtask

  // Mostly short lengths, now and then anything up to the limit
  function automatic logic [7:0] pick_length(input logic [7:0] max_len);
    int span;
    span = ($urandom_range(0, 4) == 0) ? int'(max_len) : ((max_len < 8) ? int'(max_len) : 8);
    return 8'($urandom_range(0, span));
  endfunction

  function automatic logic [7:0] over_limit(input logic [7:0] max_len);
    return (max_len == 8'd255) ? 8'd255 : 8'($urandom_range(int'(max_len) + 1, 255));
  endfunction

  // One random frame, broken frame or burst of line noise
  task automatic send_frame_mix();
    int         pick;
    int         n;
    logic [7:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      // well-formed reply; a zero count runs on until the buffer fills
      len = pick_length(cur_rmax);
      send_rx_byte(cur_hdr);
      send_rx_byte(8'($urandom));
      send_rx_byte(len);
      n = (len == 8'd0) ? BUFFER_BYTES - 3 : int'(len);
      repeat (n) send_rx_byte(8'($urandom));
    end else if (pick < 70) begin
      // well-formed data frame, sometimes with a leading zero length
      send_rx_byte(rlfr_pkg::DATA_OPEN_BYTE);
      if ($urandom_range(0, 4) == 0) send_rx_byte(8'h00);
      len = pick_length(cur_dmax);
      send_rx_byte(len);
      if (len != 8'd0) begin
        repeat (len) send_rx_byte(8'($urandom));
        send_rx_byte(8'($urandom));
      end
    end else if (pick < 80) begin
      // length over the limit
      if ($urandom_range(0, 1) == 0) begin
        send_rx_byte(cur_hdr);
        send_rx_byte(8'($urandom));
        send_rx_byte(over_limit(cur_rmax));
      end else begin
        send_rx_byte(rlfr_pkg::DATA_OPEN_BYTE);
        send_rx_byte(over_limit(cur_dmax));
      end
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 4)) send_rx_byte(8'($urandom));
    end else begin
      // truncated frame: whatever follows lands inside it
      send_rx_byte(($urandom_range(0, 1) == 0) ? cur_hdr : rlfr_pkg::DATA_OPEN_BYTE);
      repeat ($urandom_range(0, 3)) send_rx_byte(8'($urandom));
    end
  endtask

  task automatic run_random(input int target);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      if ($urandom_range(0, 15) == 0) no_gaps = !no_gaps;
      send_frame_mix();
    end
    no_gaps = 1'b0;
  endtask

  // Result side: random stall per beat, or a long hold when asked
  initial begin : result_sink
    int wait_cycles;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold) begin
        out_stall <= 1'b1;
        @(posedge clk);
        while (sink_hold) @(posedge clk);
      end
      wait_cycles = no_gaps ? 0 : $urandom_range(0, 3);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Hold off the result side for a long stretch once requested
  initial begin : sink_hold_off
    sink_hold <= 1'b0;
    wait (hold_go);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (40) @(posedge clk);
    sink_hold <= 1'b0;
  end

  // Run limit
  initial begin
    #2000000;
    $display("radio_link_frame_receiver_top regression: fail");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    rx_byte <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_index <= rlfr_pkg::REG_REPLY_HEADER;
    cfg_data <= 8'h00;
    hold_go <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults: directed bytes, then fill the block against a held result side
    foreach (OPENING_BYTES[i]) send_rx_byte(OPENING_BYTES[i]);
    hold_go <= 1'b1;
    no_gaps = 1'b1;
    repeat (24) send_rx_byte(8'($urandom));
    no_gaps = 1'b0;
    run_random(115);

    // Header equal to the data opener, widest limits; zero-count reply up to a full buffer
    drain_results();
    apply_settings(rlfr_pkg::DATA_OPEN_BYTE, 8'd255, 8'd255, 1'b0);
    send_rx_byte(rlfr_pkg::DATA_OPEN_BYTE);
    send_rx_byte(8'h00);
    send_rx_byte(8'h00);
    for (int i = 0; i < BUFFER_BYTES - 3; i++) send_rx_byte(8'(i * 4 + 1));
    run_random(115);

    // Lowest settings
    drain_results();
    apply_settings(8'h00, 8'd0, 8'd0, 1'b0);
    run_random(115);

    // Limits right at the buffer edge
    drain_results();
    apply_settings(8'hFF, 8'd60, 8'd63, 1'b0);
    run_random(115);

    // Random settings, unused index poked as well
    drain_results();
    apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    run_random(115);

    // Back to the defaults
    drain_results();
    apply_settings(8'd193, 8'd32, 8'd32, 1'b0);
    run_random(115);

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0)
      $display("radio_link_frame_receiver_top regression: pass");
    else
      $display("radio_link_frame_receiver_top regression: fail");
    $finish;
  end

endmodule

### sim.f
hdl/rlfr_pkg.sv
hdl/rlfr_parse.sv
hdl/radio_link_frame_receiver_top.sv
sim/rlfr_result_checker.sv
sim/testbench.sv
